### sv/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// shared widths, payload types and control types of the in-circle test core
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_W      = COORD_BITS + 1;      // coordinate difference
  localparam int PROD_W      = 2 * DIFF_W;          // product of two differences
  localparam int DET_W       = PROD_W + 1;          // determinant and cross terms
  localparam int NORM_W      = 2 * DIFF_W;          // squared length, unsigned
  localparam int NLO_W       = DIFF_W;              // low slice of a squared length
  localparam int NHI_W       = NORM_W - NLO_W;      // high slice of a squared length
  localparam int PP_W        = NLO_W + 1 + DET_W;   // partial product
  localparam int TERM_W      = PP_W + NLO_W + 1;    // recombined product
  localparam int SUM_W       = TERM_W + 2;          // in-circle determinant

  localparam int GEOM_STAGES = 3;
  localparam int TEST_STAGES = 3;
  localparam int NUM_STAGES  = GEOM_STAGES + TEST_STAGES;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] third_x;
    logic signed [COORD_BITS-1:0] third_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
  } pic_in_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } pic_out_t;

  typedef struct packed {
    logic signed [DET_W-1:0] det;
    logic signed [DET_W-1:0] cross_a;
    logic signed [DET_W-1:0] cross_b;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
    logic [NORM_W-1:0]       norm_p;
  } pic_geom_t;

  typedef struct packed {
    logic [GEOM_STAGES-1:0] geom_en;
    logic [TEST_STAGES-1:0] test_en;
  } pic_ctrl_t;

endpackage

### sv/pic_geom.sv
// ----------------------------------------------------------------------------
// pic_geom
// three-stage front end: edge vectors, products, determinant, cross terms
// and squared lengths relative to the first vertex
// ----------------------------------------------------------------------------
module pic_geom (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pic_pkg::pic_ctrl_t  ctrl_i,
  input  pic_pkg::pic_in_t    in_data_i,
  output pic_pkg::pic_geom_t  geom_o
);
  import pic_pkg::*;

  // stage 0: vectors relative to the first vertex
  logic signed [DIFF_W-1:0] ax_d, ay_d, bx_d, by_d, px_d, py_d;
  logic signed [DIFF_W-1:0] ax_q, ay_q, bx_q, by_q, px_q, py_q;

  assign ax_d = DIFF_W'(in_data_i.second_x) - DIFF_W'(in_data_i.first_x);
  assign ay_d = DIFF_W'(in_data_i.second_y) - DIFF_W'(in_data_i.first_y);
  assign bx_d = DIFF_W'(in_data_i.third_x)  - DIFF_W'(in_data_i.first_x);
  assign by_d = DIFF_W'(in_data_i.third_y)  - DIFF_W'(in_data_i.first_y);
  assign px_d = DIFF_W'(in_data_i.query_x)  - DIFF_W'(in_data_i.first_x);
  assign py_d = DIFF_W'(in_data_i.query_y)  - DIFF_W'(in_data_i.first_y);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.geom_en[0]) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      bx_q <= bx_d;
      by_q <= by_d;
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  // stage 1: products and squares
  logic signed [PROD_W-1:0] axby_q, aybx_q, pxby_q, pybx_q, pyax_q, pxay_q;
  logic signed [PROD_W-1:0] sqax_q, sqay_q, sqbx_q, sqby_q, sqpx_q, sqpy_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.geom_en[1]) begin
      axby_q <= ax_q * by_q;
      aybx_q <= ay_q * bx_q;
      pxby_q <= px_q * by_q;
      pybx_q <= py_q * bx_q;
      pyax_q <= py_q * ax_q;
      pxay_q <= px_q * ay_q;
      sqax_q <= ax_q * ax_q;
      sqay_q <= ay_q * ay_q;
      sqbx_q <= bx_q * bx_q;
      sqby_q <= by_q * by_q;
      sqpx_q <= px_q * px_q;
      sqpy_q <= py_q * py_q;
    end
  end

  // stage 2: determinant, cross terms, squared lengths
  pic_geom_t geom_d, geom_q;

  always_comb begin
    geom_d.det     = DET_W'(axby_q) - DET_W'(aybx_q);
    geom_d.cross_a = DET_W'(pxby_q) - DET_W'(pybx_q);
    geom_d.cross_b = DET_W'(pyax_q) - DET_W'(pxay_q);
    geom_d.norm_a  = NORM_W'(sqax_q) + NORM_W'(sqay_q);
    geom_d.norm_b  = NORM_W'(sqbx_q) + NORM_W'(sqby_q);
    geom_d.norm_p  = NORM_W'(sqpx_q) + NORM_W'(sqpy_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.geom_en[2]) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

  `ifndef ASSERT_OFF
  // squared lengths never wrap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.geom_en[2] |=> (geom_q.norm_a >= NORM_W'($past(sqax_q))))
    else $error("pic_geom: squared length overflow");
  `endif

endmodule

### sv/pic_test.sv
// ----------------------------------------------------------------------------
// pic_test
// three-stage back end: split wide products, recombine, sign decision
// ----------------------------------------------------------------------------
module pic_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pic_pkg::pic_ctrl_t  ctrl_i,
  input  pic_pkg::pic_geom_t  geom_i,
  output pic_pkg::pic_out_t   out_data_o
);
  import pic_pkg::*;

  // stage 3: partial products of squared lengths by cross terms and determinant
  logic signed [NLO_W:0] al_s, ah_s, bl_s, bh_s, pl_s, ph_s;
  logic signed [PP_W-1:0] ppal_q, ppah_q, ppbl_q, ppbh_q, pppl_q, ppph_q;
  logic det_zero_q, det_neg_q;

  assign al_s = $signed({1'b0, geom_i.norm_a[NLO_W-1:0]});
  assign ah_s = $signed({1'b0, geom_i.norm_a[NORM_W-1:NLO_W]});
  assign bl_s = $signed({1'b0, geom_i.norm_b[NLO_W-1:0]});
  assign bh_s = $signed({1'b0, geom_i.norm_b[NORM_W-1:NLO_W]});
  assign pl_s = $signed({1'b0, geom_i.norm_p[NLO_W-1:0]});
  assign ph_s = $signed({1'b0, geom_i.norm_p[NORM_W-1:NLO_W]});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.test_en[0]) begin
      ppal_q     <= al_s * geom_i.cross_a;
      ppah_q     <= ah_s * geom_i.cross_a;
      ppbl_q     <= bl_s * geom_i.cross_b;
      ppbh_q     <= bh_s * geom_i.cross_b;
      pppl_q     <= pl_s * geom_i.det;
      ppph_q     <= ph_s * geom_i.det;
      det_zero_q <= (geom_i.det == '0);
      det_neg_q  <= geom_i.det[DET_W-1];
    end
  end

  // stage 4: recombine the slices
  logic signed [TERM_W-1:0] ta_q, tb_q, tp_q;
  logic det_zero2_q, det_neg2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.test_en[1]) begin
      ta_q        <= (TERM_W'(ppah_q) <<< NLO_W) + TERM_W'(ppal_q);
      tb_q        <= (TERM_W'(ppbh_q) <<< NLO_W) + TERM_W'(ppbl_q);
      tp_q        <= (TERM_W'(ppph_q) <<< NLO_W) + TERM_W'(pppl_q);
      det_zero2_q <= det_zero_q;
      det_neg2_q  <= det_neg_q;
    end
  end

  // stage 5: in-circle determinant and decision
  logic signed [SUM_W-1:0] sum_d;
  pic_out_t res_d, res_q;

  assign sum_d = SUM_W'(ta_q) + SUM_W'(tb_q) - SUM_W'(tp_q);

  always_comb begin
    res_d.degenerate = det_zero2_q;
    res_d.inside_res = det_zero2_q || (sum_d == '0) || (sum_d[SUM_W-1] == det_neg2_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.test_en[2]) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

  `ifndef ASSERT_OFF
  // degenerate flag follows the determinant through the back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.test_en[1] && ctrl_i.test_en[2]) |=> (res_q.degenerate == $past(det_zero2_q)))
    else $error("pic_test: degenerate flag misaligned");
  `endif

endmodule

### sv/point_in_circumcircle_test_core.sv
// ----------------------------------------------------------------------------
// point_in_circumcircle_test_core
// exact in-circle predicate for a triangle and a query point
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle when the output is not stalled and
// returns one result per transaction through the six register stages of the
// datapath (vectors, products, determinant and lengths, partial products,
// recombination, decision). Collinear or coincident vertices report
// degenerate and inside. A stall on the output only holds stages that carry
// data, so empty stages keep filling.
module point_in_circumcircle_test_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pic_pkg::pic_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pic_pkg::pic_out_t out_data_o
);
  import pic_pkg::*;

  logic [NUM_STAGES-1:0] valid_d, valid_q;
  logic [NUM_STAGES-1:0] adv;
  pic_ctrl_t             ctrl;
  pic_geom_t             geom;

  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (adv[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl.geom_en = adv[GEOM_STAGES-1:0];
  assign ctrl.test_en = adv[NUM_STAGES-1:GEOM_STAGES];

  pic_geom u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_data_i (in_data_i),
    .geom_o    (geom)
  );

  pic_test u_test (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .geom_i     (geom),
    .out_data_o (out_data_o)
  );

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  `ifndef ASSERT_OFF
  // a degenerate triangle always counts as inside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.degenerate || out_data_o.inside_res))
    else $error("core: degenerate result not inside");

  // an empty output stage never backs up the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("core: input stalled with empty output stage");

  // with the input open, a transaction in the stage before the output is never lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NUM_STAGES-2] && !in_stall_o) |=> out_valid_o)
    else $error("core: transaction lost before output");
  `endif

endmodule
